@@ src/btok_pkg.sv @@
// Package for the byte stream tokenizer.
// Holds the transaction structs, token kind codes and character constants.
// Used by every module of the block; depends on nothing.
`default_nettype none
package btok_pkg;

  localparam int VALUE_W = 31;
  localparam int QDEPTH  = 4;

  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;

  typedef enum logic [2:0] {
    KIND_SEMI  = 3'd0,
    KIND_OPEN  = 3'd1,
    KIND_CLOSE = 3'd2,
    KIND_INT   = 3'd3,
    KIND_EXIT  = 3'd4,
    KIND_WORD  = 3'd5
  } tok_kind_t;

  typedef struct packed {
    logic [7:0] input_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    tok_kind_t          token_kind;
    logic [VALUE_W-1:0] token_value;
    logic               last_of_run;
  } out_item_t;

  typedef struct packed {
    logic      two;
    out_item_t first;
    out_item_t second;
  } tok_pair_t;

  function automatic logic [7:0] exit_char(input logic [1:0] pos);
    logic [7:0] ch;
    case (pos)
      2'd0:    ch = 8'h65;
      2'd1:    ch = 8'h78;
      2'd2:    ch = 8'h69;
      default: ch = 8'h74;
    endcase
    return ch;
  endfunction

  function automatic out_item_t make_tok(input tok_kind_t kind,
                                         input logic [VALUE_W-1:0] value);
    out_item_t t;
    t.token_kind  = kind;
    t.token_value = value;
    t.last_of_run = 1'b0;
    return t;
  endfunction

endpackage
`default_nettype wire

@@ src/btok_front.sv @@
// Front part of the tokenizer: accepts bytes, classifies them and tracks the run.
// Pushes the one or two tokens caused by a byte as one queue entry.
// Depends on btok_pkg.
`default_nettype none
module btok_front (
  input  logic                clk,
  input  logic                rst_n,
  input  btok_pkg::in_item_t  in_data,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                push,
  output btok_pkg::tok_pair_t push_data,
  input  logic                q_full
);
  import btok_pkg::*;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_DIGIT  = 2'd1,
    MODE_LETTER = 2'd2
  } mode_t;

  localparam int EXT_W = VALUE_W + 4;

  mode_t              mode_r, mode_nxt, mode_mid;
  logic [VALUE_W-1:0] acc_r, acc_nxt, acc_base, acc_mid;
  logic [2:0]         pos_r, pos_nxt, pos_base, pos_mid;
  logic               match_r, match_nxt, match_base, match_mid;

  logic [7:0]         c;
  logic               fin, accept;
  logic               is_digit, is_letter, is_sep;
  logic               cont_digit, cont_letter, cont;
  logic [EXT_W-1:0]   acc_x, prod;
  logic               a_v, b_v, c_v;
  out_item_t          tok_a, tok_b, tok_c;
  tok_kind_t          sep_kind;

  always_comb begin
    c         = in_data.input_byte;
    fin       = in_data.final_byte;
    in_ready  = !q_full;
    accept    = in_valid && in_ready;
    is_digit  = (c >= 8'h30) && (c <= 8'h39);
    is_letter = ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    is_sep    = (c == CH_SEMI) || (c == CH_OPEN) || (c == CH_CLOSE);
    case (c)
      CH_SEMI: sep_kind = KIND_SEMI;
      CH_OPEN: sep_kind = KIND_OPEN;
      default: sep_kind = KIND_CLOSE;
    endcase

    cont_digit  = (mode_r == MODE_DIGIT) && is_digit;
    cont_letter = (mode_r == MODE_LETTER) && is_letter;
    cont        = cont_digit || cont_letter;

    acc_base   = cont_digit ? acc_r : '0;
    pos_base   = cont_letter ? pos_r : 3'd0;
    match_base = cont_letter ? match_r : 1'b1;

    acc_x = {4'b0000, acc_base};
    prod  = (acc_x << 3) + (acc_x << 1) + {{(EXT_W-4){1'b0}}, c[3:0]};
    if (is_digit) begin
      acc_mid = (|prod[EXT_W-1:VALUE_W]) ? {VALUE_W{1'b1}} : prod[VALUE_W-1:0];
    end else begin
      acc_mid = acc_base;
    end

    pos_mid   = pos_base;
    match_mid = match_base;
    if (is_letter) begin
      if (match_base && (pos_base < 3'd4) && (c == exit_char(pos_base[1:0]))) begin
        pos_mid = pos_base + 3'd1;
      end else begin
        match_mid = 1'b0;
      end
    end

    if (cont) begin
      mode_mid = mode_r;
    end else if (is_digit) begin
      mode_mid = MODE_DIGIT;
    end else if (is_letter) begin
      mode_mid = MODE_LETTER;
    end else begin
      mode_mid = MODE_IDLE;
    end

    a_v   = !cont && ((mode_r == MODE_DIGIT) || (mode_r == MODE_LETTER));
    tok_a = (mode_r == MODE_DIGIT) ? make_tok(KIND_INT, acc_r)
          : make_tok((match_r && (pos_r == 3'd4)) ? KIND_EXIT : KIND_WORD, '0);
    b_v   = !cont && is_sep;
    tok_b = make_tok(sep_kind, '0);
    c_v   = fin && ((mode_mid == MODE_DIGIT) || (mode_mid == MODE_LETTER));
    tok_c = (mode_mid == MODE_DIGIT) ? make_tok(KIND_INT, acc_mid)
          : make_tok((match_mid && (pos_mid == 3'd4)) ? KIND_EXIT : KIND_WORD, '0);

    push_data.two    = (a_v && (b_v || c_v)) || (b_v && c_v);
    push_data.first  = a_v ? tok_a : (b_v ? tok_b : tok_c);
    push_data.second = (a_v && b_v) ? tok_b : tok_c;
    push_data.first.last_of_run  = !push_data.two;
    push_data.second.last_of_run = 1'b1;
    push = accept && (a_v || b_v || c_v);

    if (fin) begin
      mode_nxt  = MODE_IDLE;
      acc_nxt   = '0;
      pos_nxt   = 3'd0;
      match_nxt = 1'b1;
    end else begin
      mode_nxt  = mode_mid;
      acc_nxt   = acc_mid;
      pos_nxt   = pos_mid;
      match_nxt = match_mid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      acc_r   <= '0;
      pos_r   <= 3'd0;
      match_r <= 1'b1;
    end else if (accept) begin
      mode_r  <= mode_nxt;
      acc_r   <= acc_nxt;
      pos_r   <= pos_nxt;
      match_r <= match_nxt;
    end
  end

endmodule
`default_nettype wire

@@ src/btok_queue.sv @@
// Short queue of token pairs between the front and back parts.
// Flip-flop storage with a fill count; depends on btok_pkg.
`default_nettype none
module btok_queue #(
  parameter int DEPTH = btok_pkg::QDEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  btok_pkg::tok_pair_t push_data,
  output logic                full,
  input  logic                pop,
  output logic                rd_valid,
  output btok_pkg::tok_pair_t rd_data
);
  import btok_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  tok_pair_t          slot_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_push, do_pop;

  always_comb begin
    full     = (count_r == CNT_W'(DEPTH));
    rd_valid = (count_r != '0);
    rd_data  = slot_r[rd_ptr_r];
    do_push  = push && !full;
    do_pop   = pop && rd_valid;
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

@@ src/btok_back.sv @@
// Back part of the tokenizer: unpacks queue entries into single tokens.
// Drives the registered result channel; depends on btok_pkg.
`default_nettype none
module btok_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                rd_valid,
  input  btok_pkg::tok_pair_t rd_data,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output btok_pkg::out_item_t out_data
);
  import btok_pkg::*;

  logic      out_valid_r, hold_r;
  out_item_t out_item_r, hold_item_r;
  logic      out_free;

  always_comb begin
    out_free  = !out_valid_r || out_ready;
    pop       = out_free && !hold_r && rd_valid;
    out_valid = out_valid_r;
    out_data  = out_item_r;
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (hold_r) begin
        out_item_r <= hold_item_r;
      end else begin
        out_item_r  <= rd_data.first;
        hold_item_r <= rd_data.second;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      hold_r      <= 1'b0;
    end else if (out_free) begin
      if (hold_r) begin
        out_valid_r <= 1'b1;
        hold_r      <= 1'b0;
      end else begin
        out_valid_r <= rd_valid;
        hold_r      <= rd_valid && rd_data.two;
      end
    end
  end

endmodule
`default_nettype wire

@@ src/byte_stream_tokenizer_unit.sv @@
// Top level of the byte stream tokenizer.
// Connects btok_front, btok_queue and btok_back; depends on btok_pkg.
//
//   Channel  Direction  Handshake             Payload
//   in_      input      in_valid / in_ready   btok_pkg::in_item_t
//   out_     output     out_valid / out_ready btok_pkg::out_item_t
//
// One byte is accepted per cycle while the four-entry token queue has room.
// The result register delivers one token per cycle while out_ready is high, so a
// byte causing two tokens takes two output transfers. A byte's first token passes
// through a queue slot and then the result register. Reset is synchronous and
// clears the run state and the queue. Either side may stall without losing a transaction.
`default_nettype none
module byte_stream_tokenizer_unit #(
  parameter int QUEUE_DEPTH = btok_pkg::QDEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  btok_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output btok_pkg::out_item_t out_data
);
  import btok_pkg::*;

  logic      push, q_full, pop, rd_valid;
  tok_pair_t push_data, rd_data;

  btok_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  btok_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .rd_valid  (rd_valid),
    .rd_data   (rd_data)
  );

  btok_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_valid  (rd_valid),
    .rd_data   (rd_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

@@ bench/byte_stream_tokenizer_unit_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for byte_stream_tokenizer_unit: directed and random byte streams
// are tokenized by a scoreboard class and compared with every token the block returns.
// Depends on btok_pkg and the byte_stream_tokenizer_unit RTL.
module byte_stream_tokenizer_unit_tb;
  import btok_pkg::*;

  localparam logic [31:0] KEYWORD_TEXT = "exit";

  typedef enum logic [1:0] {
    RUN_IDLE   = 2'd0,
    RUN_DIGIT  = 2'd1,
    RUN_LETTER = 2'd2
  } run_mode_t;

  class tokenizer_scoreboard;
    run_mode_t          mode;
    logic [VALUE_W-1:0] number_value;
    logic [2:0]         keyword_pos;
    bit                 keyword_match;
    out_item_t          byte_tokens[$];
    out_item_t          expected_tokens[$];
    int                 failures;

    function new();
      failures = 0;
      clear_run();
    endfunction

    function void clear_run();
      mode          = RUN_IDLE;
      number_value  = '0;
      keyword_pos   = 3'd0;
      keyword_match = 1'b1;
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function bit is_letter(logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function void emit(tok_kind_t kind, logic [VALUE_W-1:0] value);
      out_item_t t;
      t.token_kind  = kind;
      t.token_value = value;
      t.last_of_run = 1'b0;
      byte_tokens.push_back(t);
    endfunction

    function void add_digit(logic [7:0] c);
      longint unsigned d;
      longint unsigned top;
      d   = 64'(c - 8'h30);
      top = (64'd1 << VALUE_W) - 1;
      if (number_value > (top - d) / 10) number_value = '1;
      else number_value = VALUE_W'(number_value * 10 + d);
    endfunction

    function void add_letter(logic [7:0] c);
      int p;
      p = keyword_pos & 3;
      if (keyword_match && keyword_pos < 4 && c == KEYWORD_TEXT[31-8*p -: 8]) begin
        keyword_pos = keyword_pos + 3'd1;
      end else begin
        keyword_match = 1'b0;
      end
    endfunction

    function void flush_run();
      if (mode == RUN_DIGIT) begin
        emit(KIND_INT, number_value);
      end else if (mode == RUN_LETTER) begin
        emit((keyword_match && keyword_pos == 3'd4) ? KIND_EXIT : KIND_WORD, '0);
      end
      clear_run();
    endfunction

    function void take_byte(in_item_t item);
      logic [7:0] c;
      out_item_t  t;
      c = item.input_byte;
      byte_tokens.delete();
      if (mode == RUN_DIGIT && is_digit(c)) begin
        add_digit(c);
      end else if (mode == RUN_LETTER && is_letter(c)) begin
        add_letter(c);
      end else begin
        flush_run();
        if (c == CH_SEMI) begin
          emit(KIND_SEMI, '0);
        end else if (c == CH_OPEN) begin
          emit(KIND_OPEN, '0);
        end else if (c == CH_CLOSE) begin
          emit(KIND_CLOSE, '0);
        end else if (is_digit(c)) begin
          mode = RUN_DIGIT;
          add_digit(c);
        end else if (is_letter(c)) begin
          mode = RUN_LETTER;
          add_letter(c);
        end
      end
      if (item.final_byte) flush_run();
      if (byte_tokens.size() > 0) begin
        t = byte_tokens.pop_back();
        t.last_of_run = 1'b1;
        byte_tokens.push_back(t);
      end
      foreach (byte_tokens[i]) expected_tokens.push_back(byte_tokens[i]);
    endfunction

    function void check_token(out_item_t got);
      out_item_t want;
      if (expected_tokens.size() == 0) begin
        $display("%0t: unexpected token kind=%0d value=%0d last=%0b", $time,
                 got.token_kind, got.token_value, got.last_of_run);
        failures++;
        return;
      end
      want = expected_tokens.pop_front();
      if (got.token_kind !== want.token_kind || got.token_value !== want.token_value ||
          got.last_of_run !== want.last_of_run) begin
        $display("%0t: expected kind=%0d value=%0d last=%0b got kind=%0d value=%0d last=%0b",
                 $time, want.token_kind, want.token_value, want.last_of_run,
                 got.token_kind, got.token_value, got.last_of_run);
        failures++;
      end
    endfunction

    function int pending_count();
      return expected_tokens.size();
    endfunction
  endclass

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  tokenizer_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int bytes_sent    = 0;

  byte_stream_tokenizer_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.take_byte(in_data);
      if (out_valid && out_ready) sb.check_token(out_data);
    end
  end

  task automatic send_byte(logic [7:0] b, logic fin);
    in_item_t item;
    item.input_byte = b;
    item.final_byte = fin;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_text(string s, logic fin_on_last);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], fin_on_last && i == s.len() - 1);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.pending_count() != 0);
    @(posedge clk);
  endtask

  function automatic logic [7:0] random_letter();
    return 8'(($urandom_range(0, 1) ? 8'h61 : 8'h41) + $urandom_range(0, 25));
  endfunction

  task automatic send_fragment();
    logic [7:0] frag[$];
    int         pick;
    int         len;
    logic       fin;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 4);
      repeat (len) frag.push_back(8'(8'h30 + $urandom_range(0, 9)));
    end else if (pick < 55) begin
      case ($urandom_range(0, 4))
        0: for (int p = 0; p < 4; p++) frag.push_back(KEYWORD_TEXT[31-8*p -: 8]);
        1: begin
          len = $urandom_range(1, 3);
          for (int p = 0; p < len; p++) frag.push_back(KEYWORD_TEXT[31-8*p -: 8]);
        end
        2: begin
          for (int p = 0; p < 4; p++) frag.push_back(KEYWORD_TEXT[31-8*p -: 8]);
          repeat ($urandom_range(1, 6)) frag.push_back(random_letter());
        end
        3: begin
          for (int p = 0; p < 4; p++) frag.push_back(KEYWORD_TEXT[31-8*p -: 8]);
          frag[$urandom_range(0, 3)] = random_letter();
        end
        default: repeat ($urandom_range(1, 8)) frag.push_back(random_letter());
      endcase
    end else if (pick < 75) begin
      case ($urandom_range(0, 2))
        0:       frag.push_back(CH_SEMI);
        1:       frag.push_back(CH_OPEN);
        default: frag.push_back(CH_CLOSE);
      endcase
    end else if (pick < 90) begin
      case ($urandom_range(0, 2))
        0:       frag.push_back(8'h20);
        1:       frag.push_back(8'($urandom_range(128, 255)));
        default: frag.push_back(8'($urandom_range(33, 47)));
      endcase
    end else begin
      frag.push_back(8'($urandom_range(0, 255)));
    end
    fin = ($urandom_range(0, 9) == 0);
    foreach (frag[i]) send_byte(frag[i], fin && i == frag.size() - 1);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 27;
    recv_idle_pct = 72;
    send_text("exit;", 1'b0);
    send_text("(7)", 1'b0);
    send_text("9999999999", 1'b1);
    send_text("a1", 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b1);
    send_text("exi", 1'b1);
    while (bytes_sent < 540) send_fragment();
    wait_drained();
    send_idle_pct = 72;
    recv_idle_pct = 27;
    while (bytes_sent < 1050) send_fragment();
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (bytes_sent < 1550) send_fragment();
    wait_drained();
    repeat (12) @(posedge clk);
    if (sb.failures == 0 && sb.pending_count() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #4800000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
